// File: rtl/core/bhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_DECKEY  = 2'd2,
        OP_DELETE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [KEY_W-1:0]  key;
        logic [IDX_W-1:0]         index;
    } cmd_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  value;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/bhq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_ram
// Single-port heap array, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               addr,
    input  wire logic [bhq_pkg::KEY_W-1:0]   wdata,
    output logic      [bhq_pkg::KEY_W-1:0]   rdata
);
    import bhq_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bhq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_engine
// Operation sequencer: read, compare and write back along one heap path.
// ----------------------------------------------------------------------------
module bhq_engine #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire bhq_pkg::cmd_t               cmd,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output bhq_pkg::rsp_t                    res,
    output logic                             mem_we,
    output logic                             mem_re,
    output logic      [AW-1:0]               mem_addr,
    output logic      [bhq_pkg::KEY_W-1:0]   mem_wdata,
    input  wire logic [bhq_pkg::KEY_W-1:0]   mem_rdata
);
    import bhq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_ROOT_RD, S_ROOT_DAT, S_DEL_RD, S_DEL_DAT,
        S_SH_RD, S_SH_WR, S_TAKE, S_LAST_DAT, S_DN_L, S_DN_R, S_DN_CMP, S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [KEY_W-1:0]  cur_reg, cur_next;
    logic signed [KEY_W-1:0]  val_reg, val_next;
    logic signed [KEY_W-1:0]  lt_key_reg, lt_key_next;
    logic                     rt_ok_reg, rt_ok_next;
    status_t                  st_reg, st_next;

    logic [AW-1:0]            parent;
    logic [AW:0]              lt_pos;
    logic [AW+1:0]            rt_pos;
    logic [31:0]              cnt_w, idx_w;
    logic signed [KEY_W-1:0]  rkey;
    logic signed [KEY_W-1:0]  best_key;
    logic                     take_lt, take_rt;

    assign parent = AW'((pos_reg - AW'(1)) >> 1);
    assign lt_pos = {pos_reg, 1'b1};
    assign rt_pos = (AW+2)'(lt_pos) + (AW+2)'(1);
    assign cnt_w  = 32'(cnt_reg);
    assign idx_w  = 32'(cmd.index);
    assign rkey   = $signed(mem_rdata);

    always_comb
    begin
        take_lt  = (lt_key_reg < cur_reg);
        best_key = take_lt ? lt_key_reg : cur_reg;
        take_rt  = rt_ok_reg && (rkey < best_key);
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        val_next    = val_reg;
        lt_key_next = lt_key_reg;
        rt_ok_next  = rt_ok_reg;
        st_next     = st_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = pos_reg;
        mem_wdata   = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    val_next = '0;
                    st_next  = ST_OK;
                    cur_next = cmd.key;
                    pos_next = AW'(cmd.index);
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            if (cnt_w >= 32'(DEPTH))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pos_next   = AW'(cnt_reg);
                                cnt_next   = cnt_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ROOT_RD;
                            end
                        end
                        OP_DECKEY:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_UP_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else if (idx_w >= cnt_w)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cur_reg < rkey)
                begin
                    // move the parent down one level and keep climbing
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROOT_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = '0;
                state_next = S_ROOT_DAT;
            end
            S_ROOT_DAT:
            begin
                val_next   = rkey;
                state_next = S_TAKE;
            end
            S_DEL_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_DEL_DAT;
            end
            S_DEL_DAT:
            begin
                val_next   = rkey;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_TAKE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = parent;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                // shift the ancestor down; the root slot is then refilled from the last entry
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                pos_next   = parent;
                state_next = S_SH_RD;
            end
            S_TAKE:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = AW'(cnt_reg - CW'(1));
                    state_next = S_LAST_DAT;
                end
            end
            S_LAST_DAT:
            begin
                cur_next   = rkey;
                pos_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (32'(lt_pos) >= cnt_w)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = AW'(lt_pos);
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                lt_key_next = rkey;
                rt_ok_next  = (32'(rt_pos) < cnt_w);
                mem_re      = (32'(rt_pos) < cnt_w);
                mem_addr    = AW'(rt_pos);
                state_next  = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (take_rt)
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = AW'(rt_pos);
                    state_next = S_DN_L;
                end
                else if (take_lt)
                begin
                    mem_wdata  = lt_key_reg;
                    pos_next   = AW'(lt_pos);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        val_reg    <= val_next;
        lt_key_reg <= lt_key_next;
        rt_ok_reg  <= rt_ok_next;
        st_reg     <= st_next;
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.value  = val_reg;
    assign res.status = st_reg;
    assign res.count  = CNT_W'(cnt_reg);

endmodule
`default_nettype wire

// File: rtl/core/binary_min_heap_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap of signed 32-bit keys in a single-port array memory.
// ----------------------------------------------------------------------------
//  channel | signals                  | beat
//  --------+--------------------------+-------------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd| op, key, index
//  rsp     | rsp_valid, rsp_stall, rsp| value, status, count
//
//  One operation at a time; a cmd beat is taken only while the engine is
//  idle. An error goes straight to the done state. Insert and decrease-key
//  climb from their slot toward the root. Extract moves the last entry to
//  the root and sifts it down. Delete first shifts the ancestors of index
//  down, then finishes as an extract. The single memory port serializes
//  every read and write of these steps.
//  Reset clears the entry count; the array contents need no clearing.
//  A finished beat waits in the rsp register while the next cmd beat is
//  taken; a stalled rsp holds the engine in its done state.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int DEPTH = bhq_pkg::DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire bhq_pkg::cmd_t  cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bhq_pkg::rsp_t       rsp
);
    import bhq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [KEY_W-1:0]  mem_wdata;
    logic [KEY_W-1:0]  mem_rdata;

    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    bhq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bhq_engine #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    // Load the payload only with a fresh result; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An error beat never carries a removed key.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.value == '0))
        else $error("error beat with nonzero value");

    // A full report means the heap holds every slot.
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (32'(rsp.count) == 32'(DEPTH)))
        else $error("full status with short count");

    // An empty report means no entries remain.
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.count == '0))
        else $error("empty status with nonzero count");

    // The count never exceeds the array depth.
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.count) <= 32'(DEPTH)))
        else $error("count beyond depth");

endmodule
`default_nettype wire

// File: sim/binary_min_heap_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test
// Self-checking bench for the min-heap queue: drives random and directed
// operations, mirrors the heap in a local model and compares every rsp beat.
// ----------------------------------------------------------------------------

// Mirror of the heap plus the queue of predicted responses.
class heap_scoreboard;
    logic signed [31:0] keys[16];
    int unsigned        num_keys;
    bhq_pkg::rsp_t      pending_rsp[$];
    int                 errors;

    function void clear();
        num_keys = 0;
        errors   = 0;
        pending_rsp.delete();
    endfunction

    function void swap_keys(int a, int b);
        logic signed [31:0] t;
        t = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    function void sift_up(int pos);
        int up;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (!(keys[pos] < keys[up]))
                break;
            swap_keys(pos, up);
            pos = up;
        end
    endfunction

    function logic signed [31:0] take_root();
        logic signed [31:0] v;
        int pos;
        int best;
        v = keys[0];
        num_keys--;
        if (num_keys > 0)
        begin
            keys[0] = keys[num_keys];
            pos = 0;
            forever
            begin
                best = pos;
                if (2*pos+1 < num_keys && keys[2*pos+1] < keys[best])
                    best = 2*pos+1;
                if (2*pos+2 < num_keys && keys[2*pos+2] < keys[best])
                    best = 2*pos+2;
                if (best == pos)
                    break;
                swap_keys(pos, best);
                pos = best;
            end
        end
        return v;
    endfunction

    // Note an accepted cmd beat and queue its predicted response.
    function void note_cmd(bhq_pkg::cmd_t c);
        bhq_pkg::rsp_t r;
        int pos;
        r.value  = '0;
        r.status = bhq_pkg::ST_OK;
        case (c.op)
            bhq_pkg::OP_INSERT:
                if (num_keys >= 16)
                    r.status = bhq_pkg::ST_FULL;
                else
                begin
                    keys[num_keys] = c.key;
                    num_keys++;
                    sift_up(num_keys - 1);
                end
            bhq_pkg::OP_EXTRACT:
                if (num_keys == 0)
                    r.status = bhq_pkg::ST_EMPTY;
                else
                    r.value = take_root();
            bhq_pkg::OP_DECKEY:
                if (c.index >= num_keys)
                    r.status = bhq_pkg::ST_RANGE;
                else
                begin
                    keys[c.index] = c.key;
                    sift_up(c.index);
                end
            default:
                if (num_keys == 0)
                    r.status = bhq_pkg::ST_EMPTY;
                else if (c.index >= num_keys)
                    r.status = bhq_pkg::ST_RANGE;
                else
                begin
                    pos = c.index;
                    while (pos > 0)
                    begin
                        swap_keys(pos, (pos - 1) / 2);
                        pos = (pos - 1) / 2;
                    end
                    r.value = take_root();
                end
        endcase
        r.count = num_keys[4:0];
        pending_rsp.push_back(r);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // Compare one rsp beat against the oldest prediction.
    task check_rsp(bhq_pkg::rsp_t got);
        bhq_pkg::rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            report($sformatf("unexpected rsp %p", got));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.value !== want.value)
            report($sformatf("value %0d, want %0d", got.value, want.value));
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.count !== want.count)
            report($sformatf("count %0d, want %0d", got.count, want.count));
    endtask
endclass

module binary_min_heap_queue_test;
    import bhq_pkg::*;

    localparam int LIMIT = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    heap_scoreboard board;
    int  send_idle_pct = 0;     // percent of cycles the sender holds back
    int  recv_stall_pct = 0;    // percent of cycles the receiver stalls
    bit  hold_off = 1'b0;       // long receiver hold-off in progress
    int  cycles = 0;

    binary_min_heap_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Bail out if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample rsp beats at the rising edge.
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_rsp(rsp);

    // Receiver: drive stall at the falling edge, forced high during a hold-off.
    always @(negedge clk)
        rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // Offer one cmd beat, idling at random first; hold it until accepted.
    // Valid stays high after the beat so the next one can follow directly.
    task automatic send_cmd(op_t op, logic signed [31:0] key, logic [3:0] index);
        cmd_t c;
        c.op = op;
        c.key = key;
        c.index = index;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_cmd(c);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(7)) - 3;
            default: return $signed($urandom());
        endcase
    endfunction

    // Random beats, biased toward insert or removal to sweep the fill level.
    task automatic send_random(int n);
        int r;
        int fill_bias;
        for (int i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                fill_bias = $urandom_range(20, 80);
            r = $urandom_range(99);
            if (r < fill_bias / 2 + 10)
                send_cmd(OP_INSERT, rand_key(), 4'($urandom()));
            else if (r < 60)
                send_cmd(OP_EXTRACT, rand_key(), 4'($urandom()));
            else if (r < 80)
                send_cmd(OP_DECKEY, rand_key(), 4'($urandom()));
            else
                send_cmd(OP_DELETE, rand_key(), 4'($urandom()));
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (board.pending_rsp.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: errors on empty, fill to full, overflow, corner keys.
        send_cmd(OP_EXTRACT, 0, 0);
        send_cmd(OP_DELETE, 0, 0);
        send_cmd(OP_DECKEY, 5, 0);
        send_cmd(OP_INSERT, 32'sh7fffffff, 4'hf);
        send_cmd(OP_INSERT, 32'sh80000000, 0);
        send_cmd(OP_DECKEY, 1, 4'hf);
        send_cmd(OP_DELETE, 0, 4'h2);
        for (int i = 0; i < 14; i++)
            send_cmd(OP_INSERT, $signed(i * 37 % 11) - 5, 0);
        send_cmd(OP_INSERT, 9, 0);
        send_cmd(OP_DECKEY, 32'sh7fffffff, 4'h3);  // larger key stays in place
        send_cmd(OP_DECKEY, 32'sh80000000, 4'hf);
        send_cmd(OP_DELETE, 0, 4'hf);
        send_cmd(OP_EXTRACT, 0, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                send_random(30);
                cmd_valid <= 1'b0;
                @(negedge clk);
            end
        join

        send_random(500);
        send_idle_pct = 84;
        send_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        send_random(450);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        send_random(500);
        drain();

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
